@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define RSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define RSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/rss_pkg.sv @@
// types and constants of the rectangle strip subtractor
package rss_pkg;

  localparam int unsigned TexSize   = 4096;
  localparam int unsigned CoordW    = $clog2(TexSize);
  localparam int unsigned SizeW     = CoordW + 1;
  localparam int unsigned SrcW      = 32;
  localparam int unsigned NumStrips = 4;

  // strip slots in emit order
  localparam int unsigned StripTop    = 0;
  localparam int unsigned StripBottom = 1;
  localparam int unsigned StripLeft   = 2;
  localparam int unsigned StripRight  = 3;

  typedef enum logic [1:0] {
    StStrip     = 2'd0,
    StNoOverlap = 2'd1,
    StCovered   = 2'd2
  } status_e;

  typedef struct packed {
    logic [SizeW-1:0]  hole_h;
    logic [SizeW-1:0]  hole_w;
    logic [CoordW-1:0] hole_y;
    logic [CoordW-1:0] hole_x;
    logic [SrcW-1:0]   source_y;
    logic [SrcW-1:0]   source_x;
    logic [SizeW-1:0]  region_h;
    logic [SizeW-1:0]  region_w;
    logic [CoordW-1:0] region_y;
    logic [CoordW-1:0] region_x;
  } item_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SizeW-1:0]  w;
    logic [SizeW-1:0]  h;
    logic [SizeW-1:0]  off_x;
    logic [SizeW-1:0]  off_y;
  } strip_t;

  typedef struct packed {
    logic                           overlap;
    logic [NumStrips-1:0]           mask;
    strip_t [NumStrips-1:0]         strips;
  } geom_t;

  typedef struct packed {
    status_e           status;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SizeW-1:0]  w;
    logic [SizeW-1:0]  h;
    logic [SrcW-1:0]   source_x;
    logic [SrcW-1:0]   source_y;
    logic              last;
  } result_t;

endpackage

@@ rtl/rss_geom.sv @@
// intersection of region and hole and the four candidate strips
module rss_geom (
  input  rss_pkg::item_t item_i,
  output rss_pkg::geom_t geom_o
);
  import rss_pkg::*;

  // far edges need one bit more than a size: coordinate plus size can reach 12286
  logic [SizeW:0]    rx1, ry1, hx1, hy1;
  logic [CoordW-1:0] ox0, oy0;
  logic [SizeW:0]    ox1, oy1;
  logic [SizeW-1:0]  mid_h, mid_off_y;
  logic              overlap;

  always_comb begin
    rx1 = {2'b0, item_i.region_x} + {1'b0, item_i.region_w};
    ry1 = {2'b0, item_i.region_y} + {1'b0, item_i.region_h};
    hx1 = {2'b0, item_i.hole_x} + {1'b0, item_i.hole_w};
    hy1 = {2'b0, item_i.hole_y} + {1'b0, item_i.hole_h};

    ox0 = (item_i.region_x > item_i.hole_x) ? item_i.region_x : item_i.hole_x;
    oy0 = (item_i.region_y > item_i.hole_y) ? item_i.region_y : item_i.hole_y;
    ox1 = (rx1 < hx1) ? rx1 : hx1;
    oy1 = (ry1 < hy1) ? ry1 : hy1;

    overlap   = ({2'b0, ox0} < ox1) && ({2'b0, oy0} < oy1);
    mid_h     = SizeW'(oy1 - {2'b0, oy0});
    mid_off_y = {1'b0, oy0 - item_i.region_y};

    geom_o.overlap = overlap;
    geom_o.mask[StripTop]    = overlap && (item_i.region_y < oy0);
    geom_o.mask[StripBottom] = overlap && (oy1 < ry1);
    geom_o.mask[StripLeft]   = overlap && (item_i.region_x < ox0);
    geom_o.mask[StripRight]  = overlap && (ox1 < rx1);

    geom_o.strips[StripTop].x     = item_i.region_x;
    geom_o.strips[StripTop].y     = item_i.region_y;
    geom_o.strips[StripTop].w     = item_i.region_w;
    geom_o.strips[StripTop].h     = mid_off_y;
    geom_o.strips[StripTop].off_x = '0;
    geom_o.strips[StripTop].off_y = '0;

    geom_o.strips[StripBottom].x     = item_i.region_x;
    geom_o.strips[StripBottom].y     = oy1[CoordW-1:0];
    geom_o.strips[StripBottom].w     = item_i.region_w;
    geom_o.strips[StripBottom].h     = SizeW'(ry1 - oy1);
    geom_o.strips[StripBottom].off_x = '0;
    geom_o.strips[StripBottom].off_y = SizeW'(oy1 - {2'b0, item_i.region_y});

    geom_o.strips[StripLeft].x     = item_i.region_x;
    geom_o.strips[StripLeft].y     = oy0;
    geom_o.strips[StripLeft].w     = {1'b0, ox0 - item_i.region_x};
    geom_o.strips[StripLeft].h     = mid_h;
    geom_o.strips[StripLeft].off_x = '0;
    geom_o.strips[StripLeft].off_y = mid_off_y;

    // corner past the texture edge wraps to the coordinate width
    geom_o.strips[StripRight].x     = ox1[CoordW-1:0];
    geom_o.strips[StripRight].y     = oy0;
    geom_o.strips[StripRight].w     = SizeW'(rx1 - ox1);
    geom_o.strips[StripRight].h     = mid_h;
    geom_o.strips[StripRight].off_x = SizeW'(ox1 - {2'b0, item_i.region_x});
    geom_o.strips[StripRight].off_y = mid_off_y;
  end

endmodule

@@ rtl/rss_pick.sv @@
// picks the next pending strip and forms its result
module rss_pick (
  input  rss_pkg::item_t                    item_i,
  input  rss_pkg::geom_t                    geom_i,
  input  logic [rss_pkg::NumStrips-1:0]     done_i,
  output logic [rss_pkg::NumStrips-1:0]     sel_o,
  output rss_pkg::result_t                  res_o
);
  import rss_pkg::*;

  logic [NumStrips-1:0] rem;
  strip_t               pick;

  always_comb begin
    rem   = geom_i.mask & ~done_i;
    sel_o = rem & (~rem + NumStrips'(1));
    pick  = '0;
    for (int i = 0; i < NumStrips; i++) begin
      if (sel_o[i]) begin
        pick = pick | geom_i.strips[i];
      end
    end

    res_o = '0;
    if (!geom_i.overlap) begin
      res_o.status = StNoOverlap;
      res_o.last   = 1'b1;
    end else if (geom_i.mask == '0) begin
      res_o.status = StCovered;
      res_o.last   = 1'b1;
    end else begin
      res_o.status   = StStrip;
      res_o.x        = pick.x;
      res_o.y        = pick.y;
      res_o.w        = pick.w;
      res_o.h        = pick.h;
      res_o.source_x = item_i.source_x + {{(SrcW-SizeW){1'b0}}, pick.off_x};
      res_o.source_y = item_i.source_y + {{(SrcW-SizeW){1'b0}}, pick.off_y};
      res_o.last     = ((rem & ~sel_o) == '0);
    end
  end

endmodule

@@ rtl/rectangle_subtract_strips.sv @@
// top level: subtracts a hole from a region and streams out the strips left
// an input item is registered in item_q, and each result in the output register res_q
// throughput: one result per cycle while m_axis_tready holds, set by the single output
// register that every result passes through; an item gives 1 to 4 results
// reset clears the input and output valid flags and the strip progress mask
module rectangle_subtract_strips (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // region_x, region_y, region_w, region_h, source_x, source_y,
  // hole_x, hole_y, hole_w, hole_h; zero fill at the top
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // strip_x, strip_y, strip_w, strip_h, strip_source_x, strip_source_y; zero fill
  output logic [119:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import rss_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned ItemW = $bits(item_t);

  item_t                item_q;
  logic                 in_vld_q, in_vld_d;
  logic [NumStrips-1:0] done_q, done_d;
  result_t              res_q;
  logic                 out_vld_q, out_vld_d;

  geom_t                geom;
  result_t              res;
  logic [NumStrips-1:0] sel;
  logic                 out_load, in_xfer, finish;

  rss_geom u_geom (
    .item_i (item_q),
    .geom_o (geom)
  );

  rss_pick u_pick (
    .item_i (item_q),
    .geom_i (geom),
    .done_i (done_q),
    .sel_o  (sel),
    .res_o  (res)
  );

  always_comb begin
    out_load      = in_vld_q && (!out_vld_q || m_axis_tready);
    finish        = out_load && res.last;
    s_axis_tready = !in_vld_q || finish;
    in_xfer       = s_axis_tvalid && s_axis_tready;

    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (finish) begin
      in_vld_d = 1'b0;
    end

    done_d = done_q;
    if (finish) begin
      done_d = '0;
    end else if (out_load) begin
      done_d = done_q | sel;
    end

    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      done_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      done_q    <= done_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_t'(s_axis_tdata[ItemW-1:0]);
    end
    if (out_load) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {6'd0, res_q.source_y, res_q.source_x,
                          res_q.h, res_q.w, res_q.y, res_q.x};

  `RSS_ASSERT(a_single_is_last,
    m_axis_tvalid && (m_axis_tuser != StStrip) |-> m_axis_tlast,
    "no-overlap or covered result without last")
  `RSS_ASSERT(a_done_in_mask,
    in_vld_q |-> ((done_q & ~geom.mask) == '0),
    "strip progress outside the strip mask")
  `RSS_ASSERT_ALWAYS(a_idle_done_clear,
    !in_vld_q |-> (done_q == '0),
    "strip progress left over with no item held")
  `RSS_ASSERT(a_item_held,
    out_load && !res.last |=> in_vld_q && $stable(item_q),
    "item dropped before its last strip")

endmodule
